// File: rtl/lcpe_pkg.sv
// Shared types and constants for the Lagrange curve point evaluator.
// Used by lcpe_div and lagrange_curve_point_eval; depends on nothing.
package lcpe_pkg;

  localparam int unsigned CoordW  = 9;
  localparam int unsigned ParamW  = 16;
  localparam int unsigned OutW    = 24;
  localparam int unsigned CountW  = 5;
  localparam int unsigned WeightW = 41;
  localparam int unsigned FracW   = 16;

  localparam logic [CountW-1:0] CountReset = 5'd2;

  localparam logic signed [WeightW-1:0] WeightOne = 41'sd1 <<< 24;

  // Command codes carried in s_axis_tuser
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/lcpe_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lcpe_pkg for its control and status structs.
module lcpe_div #(
  parameter int unsigned NumW = 37,
  parameter int unsigned DenW = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcpe_pkg::div_ctrl_t ctrl_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [DenW-1:0]     den_i,
  output lcpe_pkg::div_stat_t stat_o,
  output logic [NumW-1:0]     quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_q, rem_d;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW:0]   trial;

  always_comb begin
    trial = {rem_q[DenW-1:0], num_q[NumW-1]};
    num_d = {num_q[NumW-2:0], 1'b0};
    rem_d = trial;
    if (trial >= {1'b0, den_q}) begin
      rem_d    = trial - {1'b0, den_q};
      num_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && !busy_q) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = num_q;

endmodule

// File: rtl/lagrange_curve_point_eval.sv
// Lagrange curve point evaluator: top level, sequencer, point store and shared multiplier.
// Depends on lcpe_pkg and instantiates lcpe_div.
//
// Channel   | Dir  | Word                                   | Handshake
// ----------+------+----------------------------------------+-------------------
// s_axis    | in   | load point or evaluate at parameter    | tvalid / tready
// m_axis    | out  | curve point (x, y) and saturation flag | tvalid / tready
// cfg       | in   | point_count register                   | cfg_valid / cfg_ready
//
// A load word is written to the point store while the sequencer stays idle. An
// evaluate word with n points runs n*(n-1) factor divisions on the shared serial
// divider (NumW = 33 + clog2(MAX_POINTS)), each with setup and a weight update on
// the shared multiplier, then multiplies x and y by the weight for each point.
// Reset clears control state only; the point store holds garbage until loaded.
// s_axis_tready is low while an evaluation runs; a finished point waits in the
// output register and stalls the sequencer only if the previous one is untaken.
module lagrange_curve_point_eval #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,      // point_count
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // point_index[3:0], point_x[12:4], point_y[21:13],
                                     // eval_param[37:22], zero fill[39:38]
  input  logic        s_axis_tuser,  // cmd
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // curve_x[23:0], curve_y[47:24]
  output logic        m_axis_tuser   // saturated
);

  localparam int unsigned NW   = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW   = 18 + NW;            // signed knot distance
  localparam int unsigned DENW = 16 + NW;            // divisor 65535*|i-j|
  localparam int unsigned NUMW = 33 + NW;            // rounded dividend
  localparam int unsigned FW   = 18 + NW;            // signed factor
  localparam int unsigned WW   = lcpe_pkg::WeightW;
  localparam int unsigned PW   = WW + FW;            // multiplier product
  localparam int unsigned SW   = 51 + NW;            // coordinate sums
  localparam int unsigned XW   = lcpe_pkg::CoordW;
  localparam int unsigned OW   = lcpe_pkg::OutW;

  localparam logic signed [PW-1:0] WHi = $signed(PW'(1) << 39);
  localparam logic signed [PW-1:0] WLo = -WHi;
  localparam logic signed [SW-1:0] OHi = $signed(SW'((1 << (OW - 1)) - 1));
  localparam logic signed [SW-1:0] OLo = -OHi - SW'(1);

  typedef enum logic [3:0] {
    StIdle, StNextI, StFact, StDiv, StMulW, StUpdW, StMulX, StMulY, StAccY, StFinal
  } state_e;

  // input unpack
  logic [3:0]             in_idx;
  logic [XW-1:0]          in_x, in_y;
  logic [15:0]            in_par;
  assign in_idx = s_axis_tdata[3:0];
  assign in_x   = s_axis_tdata[12:4];
  assign in_y   = s_axis_tdata[21:13];
  assign in_par = s_axis_tdata[37:22];

  state_e                 state_q;

  logic [lcpe_pkg::CountW-1:0] count_q;
  logic [CW-1:0]          n_q, i_q, j_q;
  logic [15:0]            e_q;
  logic signed [WW-1:0]   w_q;
  logic signed [FW-1:0]   f_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [SW-1:0]   sx_q, sy_q;
  logic [2*XW-1:0]        pt_q;
  logic                   fneg_q;
  logic [2*XW-1:0]        store_q [MAX_POINTS];
  logic                   out_valid_q;
  logic [OW-1:0]          out_x_q, out_y_q;
  logic                   out_sat_q;

  // clamped point count
  logic [CW-1:0]          n_eff;
  always_comb begin
    priority if (32'(count_q) < 32'd2) n_eff = CW'(2);
    else if (32'(count_q) > 32'(MAX_POINTS)) n_eff = CW'(MAX_POINTS);
    else n_eff = CW'(count_q);
  end

  // factor setup: d = (n-1)*e - 65535*j, den = 65535*|i-j|
  logic [DW-1:0]          d_pos, d_jk, d_raw, d_mag;
  logic [CW-1:0]          m_dist;
  logic [DENW-1:0]        den;
  logic [NUMW-1:0]        dividend;
  always_comb begin
    d_pos    = DW'(n_q - CW'(1)) * DW'(e_q);
    d_jk     = (DW'(j_q) << 16) - DW'(j_q);
    d_raw    = d_pos - d_jk;
    d_mag    = d_raw[DW-1] ? (~d_raw + DW'(1)) : d_raw;
    m_dist   = (i_q > j_q) ? (i_q - j_q) : (j_q - i_q);
    den      = (DENW'(m_dist) << 16) - DENW'(m_dist);
    dividend = (NUMW'(d_mag) << 16) + NUMW'(den >> 1);
  end

  lcpe_pkg::div_ctrl_t    div_ctrl;
  lcpe_pkg::div_stat_t    div_stat;
  logic [NUMW-1:0]        div_quo;
  logic [FW-1:0]          quo_t;
  assign quo_t = FW'(div_quo);
  assign div_ctrl.start = (state_q == StFact) && (j_q != n_q) && (j_q != i_q);

  lcpe_div #(.NumW(NUMW), .DenW(DENW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (dividend),
    .den_i  (den),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  // shared multiplier: weight times factor or coordinate
  logic signed [FW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  always_comb begin
    unique case (state_q)
      StMulX:  mul_b = $signed(FW'(pt_q[XW-1:0]));
      StMulY:  mul_b = $signed(FW'(pt_q[2*XW-1:XW]));
      default: mul_b = f_q;
    endcase
    mul_p = PW'(w_q) * PW'(mul_b);
  end

  // round half away from zero by 2^16, then clamp the weight
  logic [PW-1:0]          p_mag, p_rq;
  logic signed [PW-1:0]   p_rs, w_next;
  always_comb begin
    p_mag = prod_q[PW-1] ? (~prod_q + PW'(1)) : prod_q;
    p_rq  = (p_mag + PW'(32768)) >> 16;
    p_rs  = prod_q[PW-1] ? -$signed(p_rq) : $signed(p_rq);
    priority if (p_rs > WHi) w_next = WHi;
    else if (p_rs < WLo) w_next = WLo;
    else w_next = p_rs;
  end

  function automatic logic signed [SW-1:0] round_sum(input logic signed [SW-1:0] v);
    logic [SW-1:0] mag;
    logic [SW-1:0] q;
    mag = v[SW-1] ? (~v + SW'(1)) : v;
    q   = (mag + SW'(32768)) >> 16;
    return v[SW-1] ? -$signed(q) : $signed(q);
  endfunction

  logic signed [SW-1:0]   rx, ry, cx, cy;
  logic                   sat;
  always_comb begin
    rx  = round_sum(sx_q);
    ry  = round_sum(sy_q);
    sat = 1'b0;
    cx  = rx;
    cy  = ry;
    if (rx > OHi) begin cx = OHi; sat = 1'b1; end
    if (rx < OLo) begin cx = OLo; sat = 1'b1; end
    if (ry > OHi) begin cy = OHi; sat = 1'b1; end
    if (ry < OLo) begin cy = OLo; sat = 1'b1; end
  end

  logic s_fire, load_ok;
  logic [NW-1:0] widx;
  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign widx    = NW'(in_idx);
  assign load_ok = 32'(in_idx) < 32'(MAX_POINTS);

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready     = 1'b1;

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= lcpe_pkg::CountReset;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= CW'(2);
    end else begin
      if (cfg_valid) count_q <= cfg_data;
      // raise valid for a finished point, else drop it once taken
      if (state_q == StFinal && (!out_valid_q || m_axis_tready)) out_valid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (s_fire && s_axis_tuser == lcpe_pkg::CmdEval) begin
            n_q     <= n_eff;
            i_q     <= '0;
            state_q <= StNextI;
          end
        end
        StNextI: begin
          j_q <= '0;
          if (i_q == n_q) state_q <= StFinal;
          else state_q <= StFact;
        end
        StFact: begin
          if (j_q == n_q) state_q <= StMulX;
          else if (j_q == i_q) j_q <= j_q + CW'(1);
          else state_q <= StDiv;
        end
        StDiv: begin
          if (div_stat.done) state_q <= StMulW;
        end
        StMulW: state_q <= StUpdW;
        StUpdW: begin
          j_q     <= j_q + CW'(1);
          state_q <= StFact;
        end
        StMulX: state_q <= StMulY;
        StMulY: state_q <= StAccY;
        StAccY: begin
          i_q     <= i_q + CW'(1);
          state_q <= StNextI;
        end
        StFinal: begin
          // hold until the previous point is taken
          if (!out_valid_q || m_axis_tready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_fire) begin
      e_q  <= in_par;
      sx_q <= '0;
      sy_q <= '0;
    end
    if (state_q == StNextI && i_q != n_q) begin
      pt_q <= store_q[i_q[NW-1:0]];
      w_q  <= lcpe_pkg::WeightOne;
    end
    if (div_ctrl.start) fneg_q <= d_raw[DW-1] ^ (i_q < j_q);
    if (state_q == StDiv && div_stat.done)
      f_q <= fneg_q ? -$signed(quo_t) : $signed(quo_t);
    if (state_q == StMulW || state_q == StMulX || state_q == StMulY) prod_q <= mul_p;
    if (state_q == StUpdW) w_q <= WW'(w_next);
    if (state_q == StMulY) sx_q <= sx_q + SW'(prod_q);
    if (state_q == StAccY) sy_q <= sy_q + SW'(prod_q);
    if (state_q == StFinal && (!out_valid_q || m_axis_tready)) begin
      out_x_q   <= OW'(cx);
      out_y_q   <= OW'(cy);
      out_sat_q <= sat;
    end
  end

  // point store: written by load words
  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tuser == lcpe_pkg::CmdLoad && load_ok)
      store_q[widx] <= {in_y, in_x};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = out_sat_q;

endmodule

// File: dv/lagrange_curve_point_eval_test.sv
// Testbench for lagrange_curve_point_eval: loads control points, evaluates curve points
// and checks each result word against an in-bench fixed-point Lagrange predictor.
// Depends on lcpe_pkg and the RTL of lagrange_curve_point_eval.
`timescale 1ns / 1ps

module lagrange_curve_point_eval_test;

  localparam int unsigned NumSlots  = 16;
  localparam longint      CycleMax  = 4_000_000;
  localparam longint      WeightCap = longint'(1) <<< 39;

  typedef struct {
    logic              cmd;
    logic [3:0]        slot;
    logic [8:0]        px;
    logic [8:0]        py;
    logic [15:0]       param;
  } work_t;

  typedef struct {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic               sat;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  lagrange_curve_point_eval u_top (
    .clk_i,
    .rst_ni,
    .cfg_valid,
    .cfg_ready,
    .cfg_data,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the block state, kept in step with accepted words
  logic [8:0]  shadow_x [NumSlots];
  logic [8:0]  shadow_y [NumSlots];
  logic [4:0]  shadow_count = lcpe_pkg::CountReset;

  work_t  pending_words [$];
  point_t expected_points [$];
  work_t  word_on_bus;

  int     fail_count   = 0;
  int     points_seen  = 0;
  int     sat_seen     = 0;
  int     words_sent   = 0;
  longint cycle_count  = 0;

  // Round half away from zero
  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint basis_weight(int i, int n, longint e);
    longint w, d, f, den;
    int     diff;
    w = longint'(1) <<< 24;
    for (int j = 0; j < n; j++) begin
      if (j == i) continue;
      d    = longint'(n - 1) * e - longint'(65535) * j;
      diff = i - j;
      den  = longint'(65535) * ((diff < 0) ? -diff : diff);
      f    = round_div(d * 65536, den);
      if (diff < 0) f = -f;
      w = round_div(w * f, 65536);
      if (w > WeightCap) w = WeightCap;
      if (w < -WeightCap) w = -WeightCap;
    end
    return w;
  endfunction

  function automatic int active_points(logic [4:0] count);
    if (count < 2) return 2;
    if (count > NumSlots) return NumSlots;
    return int'(count);
  endfunction

  // Apply one accepted word to the shadow state; queue the curve point it yields
  function automatic void track_word(work_t wd);
    longint sx, sy, w, rx, ry;
    int     n;
    point_t pt;
    if (wd.cmd == lcpe_pkg::CmdLoad) begin
      shadow_x[wd.slot] = wd.px;
      shadow_y[wd.slot] = wd.py;
      return;
    end
    n  = active_points(shadow_count);
    sx = 0;
    sy = 0;
    for (int i = 0; i < n; i++) begin
      w  = basis_weight(i, n, longint'(wd.param));
      sx += longint'(shadow_x[i]) * w;
      sy += longint'(shadow_y[i]) * w;
    end
    rx = round_div(sx, 65536);
    ry = round_div(sy, 65536);
    pt.sat = 1'b0;
    if (rx > 8388607)  begin rx = 8388607;  pt.sat = 1'b1; end
    if (rx < -8388608) begin rx = -8388608; pt.sat = 1'b1; end
    if (ry > 8388607)  begin ry = 8388607;  pt.sat = 1'b1; end
    if (ry < -8388608) begin ry = -8388608; pt.sat = 1'b1; end
    pt.cx = rx[23:0];
    pt.cy = ry[23:0];
    expected_points.push_back(pt);
  endfunction

  // Driver: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_word(word_on_bus);
        words_sent++;
      end
      // Hold the word until it is taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          word_on_bus = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= word_on_bus.cmd;
          s_axis_tdata  <= {2'b00, word_on_bus.param, word_on_bus.py,
                            word_on_bus.px, word_on_bus.slot};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken point, stall on a rotating bit pattern
  logic [15:0] stall_pattern = 16'hFFFF;
  int          stall_phase   = 0;

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        points_seen++;
        if (m_axis_tuser) sat_seen++;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d sat=%0b", $time,
                   $signed(m_axis_tdata[23:0]), $signed(m_axis_tdata[47:24]), m_axis_tuser);
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          if (m_axis_tdata[23:0] !== want.cx) begin
            $display("%0t: curve_x expected %0d got %0d", $time, want.cx,
                     $signed(m_axis_tdata[23:0]));
            fail_count++;
          end
          if (m_axis_tdata[47:24] !== want.cy) begin
            $display("%0t: curve_y expected %0d got %0d", $time, want.cy,
                     $signed(m_axis_tdata[47:24]));
            fail_count++;
          end
          if (m_axis_tuser !== want.sat) begin
            $display("%0t: saturated expected %0b got %0b", $time, want.sat, m_axis_tuser);
            fail_count++;
          end
        end
      end
      // Switch stall mode now and then: always ready, or a fresh random pattern
      stall_phase++;
      if (stall_phase == 300) begin
        stall_phase   = 0;
        stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end else begin
        stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      end
      m_axis_tready <= stall_pattern[0];
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleMax) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("lagrange_curve_point_eval_test NOT OK");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_words.size() > 0 || s_axis_tvalid || expected_points.size() > 0)
      @(posedge clk_i);
    // Let a trailing load word settle
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_count(logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    shadow_count = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic work_t load_word(logic [3:0] slot, logic [8:0] x, logic [8:0] y);
    work_t wd;
    wd.cmd   = lcpe_pkg::CmdLoad;
    wd.slot  = slot;
    wd.px    = x;
    wd.py    = y;
    wd.param = 16'($urandom);
    return wd;
  endfunction

  function automatic work_t eval_word(logic [15:0] param);
    work_t wd;
    wd.cmd   = lcpe_pkg::CmdEval;
    wd.slot  = 4'($urandom);
    wd.px    = 9'($urandom);
    wd.py    = 9'($urandom);
    wd.param = param;
    return wd;
  endfunction

  // Random words for one count setting: mostly evaluations, some reloads,
  // and evaluations landing on knots or at the ends of the range
  task automatic queue_random(int n, int words);
    int          pick;
    logic [15:0] t;
    for (int k = 0; k < words; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        pending_words.push_back(load_word(4'($urandom), 9'($urandom), 9'($urandom)));
      end else begin
        case ($urandom_range(0, 9))
          0:       t = 16'd0;
          1:       t = 16'hFFFF;
          2, 3:    t = 16'((65535 * $urandom_range(0, n - 1) + (n - 1) / 2) / (n - 1));
          default: t = 16'($urandom);
        endcase
        pending_words.push_back(eval_word(t));
      end
    end
  endtask

  initial begin
    logic [4:0] counts [10] = '{5'd3, 5'd4, 5'd16, 5'd0, 5'd5, 5'd31, 5'd1, 5'd7, 5'd2, 5'd6};
    int         n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill every slot with extreme and random corners, then evaluate
    // at the reset count of two points
    for (int s = 0; s < NumSlots; s++) begin
      case (s % 4)
        0: pending_words.push_back(load_word(4'(s), 9'd0, 9'd511));
        1: pending_words.push_back(load_word(4'(s), 9'd511, 9'd0));
        2: pending_words.push_back(load_word(4'(s), 9'd511, 9'd511));
        default: pending_words.push_back(load_word(4'(s), 9'($urandom), 9'($urandom)));
      endcase
    end
    pending_words.push_back(eval_word(16'd0));
    pending_words.push_back(eval_word(16'hFFFF));
    pending_words.push_back(eval_word(16'h8000));
    pending_words.push_back(eval_word(16'd1));
    pending_words.push_back(eval_word(16'hAAAA));
    wait_idle();

    // Random phases over several counts, including out-of-range ones
    foreach (counts[p]) begin
      write_count(counts[p]);
      n = active_points(counts[p]);
      queue_random(n, (n >= 8) ? 12 : 130);
      wait_idle();
    end

    $display("sent %0d words over %0d count settings; checked %0d curve points, %0d saturated",
             words_sent, $size(counts) + 1, points_seen, sat_seen);
    if (fail_count == 0) begin
      $display("lagrange_curve_point_eval_test OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("lagrange_curve_point_eval_test NOT OK");
    end
    $finish;
  end

endmodule

// File: lagrange_curve_point_eval.f
rtl/lcpe_pkg.sv
rtl/lcpe_div.sv
rtl/lagrange_curve_point_eval.sv
dv/lagrange_curve_point_eval_test.sv
